@@ rtl/catmull_rom_path_sampler_top_macros.svh @@
// assertion macros for the path sampler checker
`ifndef CATMULL_ROM_PATH_SAMPLER_TOP_MACROS_SVH
`define CATMULL_ROM_PATH_SAMPLER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define CMR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("path sampler check failed");

// next-cycle implication, checked outside reset
`define CMR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("path sampler check failed");

`endif

@@ rtl/cmr_pkg.sv @@
// ----------------------------------------------------------------------------
// cmr_pkg
// constants, state codes and helpers of the catmull-rom path sampler
// ----------------------------------------------------------------------------
`default_nettype none

package cmr_pkg;

    localparam int VALUE_BITS = 24;
    localparam int MAX_STEPS  = 32;
    localparam int SF_BITS    = 16;
    localparam logic [SF_BITS-1:0] SF_RESET = 16'd2560;
    localparam int STEP_SHIFT = 20;

    localparam int N_BITS     = $clog2(MAX_STEPS + 1);
    localparam int DIFF_BITS  = VALUE_BITS + 1;
    localparam int V_BITS     = VALUE_BITS + 5;
    localparam int COEF_BITS  = 3 * N_BITS;
    localparam int MUL_A_BITS = ((DIFF_BITS > COEF_BITS) ? DIFF_BITS : COEF_BITS) + 1;
    localparam int MUL_B_BITS = ((V_BITS > DIFF_BITS) ? V_BITS : DIFF_BITS) + 1;
    localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
    localparam int ACC_BITS   = COEF_BITS + V_BITS + 2;
    localparam int SUM_BITS   = 2 * DIFF_BITS;
    localparam int ROOT_BITS  = DIFF_BITS;
    localparam int QUO_BITS   = ACC_BITS - 1;
    localparam int DVS_BITS   = COEF_BITS + 1;
    localparam int IT_BITS    = $clog2(QUO_BITS);

    typedef logic signed [VALUE_BITS-1:0] value_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_LEN,
        ST_SQRT,
        ST_STEPS,
        ST_SEG,
        ST_CUBE,
        ST_COEF,
        ST_PMUL,
        ST_AMUL,
        ST_DPREP,
        ST_DIV,
        ST_FIX,
        ST_OUT,
        ST_SEGEND
    } state_t;

    localparam logic signed [ACC_BITS:0] SAT_HI =
        {{(ACC_BITS + 2 - VALUE_BITS){1'b0}}, {(VALUE_BITS - 1){1'b1}}};
    localparam logic signed [ACC_BITS:0] SAT_LO = ~SAT_HI;

    function automatic value_t sat_value(input logic signed [ACC_BITS:0] v);
        value_t r;
        if (v > SAT_HI)
        begin
            r = SAT_HI[VALUE_BITS-1:0];
        end
        else if (v < SAT_LO)
        begin
            r = SAT_LO[VALUE_BITS-1:0];
        end
        else
        begin
            r = v[VALUE_BITS-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/catmull_rom_path_sampler_top.sv @@
// ----------------------------------------------------------------------------
// catmull_rom_path_sampler_top
// samples catmull-rom segments between keypoints into short sub-segments
// ----------------------------------------------------------------------------
// Keypoints enter one beat at a time and the block is busy until every
// sub-segment that the keypoint causes has been delivered. One shared
// multiplier (a product register behind it), a bit-serial isqrt and a
// bit-serial restoring divider do all of the math under one sequencer.
// Segment setup uses three squares, 25 isqrt steps and one scaling multiply
// per length, and two more multiplies for n squared and cubed. Each result
// then needs four coefficient multiplies, and for each of the three
// coordinates a three-term multiply-accumulate and for each of the three
// attributes a single multiply, each followed by one divide. A keypoint that
// only fills the window returns from the load state to idle. Results are held stable until taken.
`default_nettype none

module catmull_rom_path_sampler_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [cmr_pkg::SF_BITS-1:0]   cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [cmr_pkg::VALUE_BITS-1:0] pos_x,
    input  wire logic signed [cmr_pkg::VALUE_BITS-1:0] pos_y,
    input  wire logic signed [cmr_pkg::VALUE_BITS-1:0] pos_z,
    input  wire logic signed [cmr_pkg::VALUE_BITS-1:0] scale_value,
    input  wire logic signed [cmr_pkg::VALUE_BITS-1:0] twist_value,
    input  wire logic signed [cmr_pkg::VALUE_BITS-1:0] falloff_value,
    input  wire logic                          last_point,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [cmr_pkg::VALUE_BITS-1:0] start_x,
    output logic signed [cmr_pkg::VALUE_BITS-1:0] start_y,
    output logic signed [cmr_pkg::VALUE_BITS-1:0] start_z,
    output logic signed [cmr_pkg::VALUE_BITS-1:0] end_x,
    output logic signed [cmr_pkg::VALUE_BITS-1:0] end_y,
    output logic signed [cmr_pkg::VALUE_BITS-1:0] end_z,
    output logic signed [cmr_pkg::VALUE_BITS-1:0] out_scale,
    output logic signed [cmr_pkg::VALUE_BITS-1:0] out_twist,
    output logic signed [cmr_pkg::VALUE_BITS-1:0] out_falloff,
    output logic                               last_sample
);

    localparam int NB  = cmr_pkg::N_BITS;
    localparam int DB  = cmr_pkg::DIFF_BITS;
    localparam int VB  = cmr_pkg::V_BITS;
    localparam int CB  = cmr_pkg::COEF_BITS;
    localparam int MA  = cmr_pkg::MUL_A_BITS;
    localparam int MB  = cmr_pkg::MUL_B_BITS;
    localparam int PB  = cmr_pkg::PROD_BITS;
    localparam int AB  = cmr_pkg::ACC_BITS;
    localparam int SB  = cmr_pkg::SUM_BITS;
    localparam int RB  = cmr_pkg::ROOT_BITS;
    localparam int QB  = cmr_pkg::QUO_BITS;
    localparam int DVB = cmr_pkg::DVS_BITS;
    localparam int IB  = cmr_pkg::IT_BITS;

    cmr_pkg::state_t state_reg, state_next;

    // control
    logic [cmr_pkg::SF_BITS-1:0] sf_reg;
    logic [1:0]    held_reg;
    logic          final_reg;
    logic          pass_reg;
    logic [1:0]    k_reg;
    logic          ph_reg;
    logic [IB-1:0] it_reg;
    logic          attr_reg;

    // window and arriving keypoint
    cmr_pkg::value_t pa_reg [3];
    cmr_pkg::value_t pb_reg [3];
    cmr_pkg::value_t pc_reg [3];
    cmr_pkg::value_t pd_reg [3];
    cmr_pkg::value_t ab_reg [3];
    cmr_pkg::value_t ac_reg [3];
    cmr_pkg::value_t ad_reg [3];
    logic            last_reg;

    // datapath
    logic signed [PB-1:0] prod_reg;
    logic [SB-1:0]        sum_reg;
    logic [SB-1:0]        sq_x_reg;
    logic [RB+1:0]        sq_rem_reg;
    logic [RB-1:0]        root_reg;
    logic [NB-1:0]        n_reg;
    logic [NB-1:0]        n2_reg;
    logic [2*NB-1:0]      nsq_reg;
    logic [CB-1:0]        ncb_reg;
    logic [NB-1:0]        s_reg;
    logic [2*NB-1:0]      t2_reg;
    logic [CB-1:0]        t3_reg;
    logic [CB-1:0]        c1_reg;
    logic [CB-1:0]        c2_reg;
    logic signed [AB-1:0] acc_reg;
    logic [QB-1:0]        dv_num_reg;
    logic [DVB-1:0]       dv_rem_reg;
    logic [DVB-1:0]       dv_den_reg;
    logic                 dv_neg_reg;
    cmr_pkg::value_t      st_reg [3];
    cmr_pkg::value_t      en_reg [3];
    cmr_pkg::value_t      oa_reg [3];

    // per-component terms
    logic signed [DB-1:0] d_cb, d_dc, d_db, d_ca, d_attr, len_diff;
    logic signed [VB-1:0] dcb_v, m1_v, m2_v, v1_v, v2_v;
    logic [NB-1:0]        t_val;

    assign t_val    = s_reg + NB'(1);
    assign d_cb     = DB'(pc_reg[k_reg]) - DB'(pb_reg[k_reg]);
    assign d_dc     = DB'(pd_reg[k_reg]) - DB'(pc_reg[k_reg]);
    assign d_db     = DB'(pd_reg[k_reg]) - DB'(pb_reg[k_reg]);
    assign d_ca     = DB'(pc_reg[k_reg]) - DB'(pa_reg[k_reg]);
    assign d_attr   = DB'(ac_reg[k_reg]) - DB'(ab_reg[k_reg]);
    assign len_diff = pass_reg ? d_dc : d_cb;
    assign dcb_v    = VB'(d_cb);
    assign m1_v     = VB'(d_ca);
    assign m2_v     = final_reg ? VB'(d_cb) : VB'(d_db);
    assign v1_v     = (dcb_v <<< 2) + (dcb_v <<< 1) - (m1_v <<< 1) - m2_v;
    assign v2_v     = m1_v + m2_v - (dcb_v <<< 2);

    // shared multiplier operand select
    logic signed [MA-1:0] mul_a;
    logic signed [MB-1:0] mul_b;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            cmr_pkg::ST_LEN:
            begin
                mul_a = MA'(len_diff);
                mul_b = MB'(len_diff);
            end
            cmr_pkg::ST_STEPS:
            begin
                mul_a = MA'($signed({1'b0, sf_reg}));
                mul_b = MB'($signed({1'b0, root_reg}));
            end
            cmr_pkg::ST_CUBE:
            begin
                mul_a = (k_reg == 2'd0) ? MA'($signed({1'b0, n_reg}))
                                        : MA'($signed({1'b0, nsq_reg}));
                mul_b = MB'($signed({1'b0, n_reg}));
            end
            cmr_pkg::ST_COEF:
            begin
                case (k_reg)
                    2'd0:
                    begin
                        mul_a = MA'($signed({1'b0, t_val}));
                        mul_b = MB'($signed({1'b0, t_val}));
                    end
                    2'd1:
                    begin
                        mul_a = MA'($signed({1'b0, t2_reg}));
                        mul_b = MB'($signed({1'b0, t_val}));
                    end
                    2'd2:
                    begin
                        mul_a = MA'($signed({1'b0, nsq_reg}));
                        mul_b = MB'($signed({1'b0, t_val}));
                    end
                    default:
                    begin
                        mul_a = MA'($signed({1'b0, t2_reg}));
                        mul_b = MB'($signed({1'b0, n_reg}));
                    end
                endcase
            end
            cmr_pkg::ST_PMUL:
            begin
                case (it_reg[1:0])
                    2'd0:
                    begin
                        mul_a = MA'($signed({1'b0, c1_reg}));
                        mul_b = MB'(m1_v);
                    end
                    2'd1:
                    begin
                        mul_a = MA'($signed({1'b0, c2_reg}));
                        mul_b = MB'(v1_v);
                    end
                    default:
                    begin
                        mul_a = MA'($signed({1'b0, t3_reg}));
                        mul_b = MB'(v2_v);
                    end
                endcase
            end
            cmr_pkg::ST_AMUL:
            begin
                mul_a = MA'($signed({1'b0, s_reg, 1'b0}));
                mul_b = MB'(d_attr);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // isqrt step
    logic [RB+2:0] sq_sh, sq_trial;
    logic          sq_ge;

    assign sq_sh    = {sq_rem_reg[RB:0], sq_x_reg[SB-1:SB-2]};
    assign sq_trial = (RB+3)'({root_reg, 2'b01});
    assign sq_ge    = (sq_sh >= sq_trial);

    // step count from the scaled length
    logic [PB-STEP_SHIFT_L-1:0] n_full;
    localparam int STEP_SHIFT_L = cmr_pkg::STEP_SHIFT;
    logic [NB-1:0] n_sat;

    assign n_full = prod_reg[PB-1:STEP_SHIFT_L];
    assign n_sat  = (n_full > (PB-STEP_SHIFT_L)'(cmr_pkg::MAX_STEPS))
                    ? NB'(cmr_pkg::MAX_STEPS) : n_full[NB-1:0];

    // divider prep, step and fix-up
    logic signed [AB-1:0] dp_x, dp_mag;
    logic [CB-1:0]        dp_bias;
    logic [DVB:0]         dv_trial;
    logic                 dv_ge;
    logic signed [AB-1:0] fx_q, fx_qs;
    cmr_pkg::value_t      fx_base, fx_val;

    assign dp_bias  = attr_reg ? CB'(n_reg) : ncb_reg;
    assign dp_x     = acc_reg + AB'($signed({1'b0, dp_bias}));
    assign dp_mag   = dp_x[AB-1] ? -dp_x : dp_x;
    assign dv_trial = {dv_rem_reg, dv_num_reg[QB-1]};
    assign dv_ge    = (dv_trial >= {1'b0, dv_den_reg});
    assign fx_q     = $signed({1'b0, dv_num_reg});
    assign fx_qs    = dv_neg_reg ? -(fx_q + AB'(dv_rem_reg != '0)) : fx_q;
    assign fx_base  = attr_reg ? ab_reg[k_reg] : pb_reg[k_reg];
    assign fx_val   = cmr_pkg::sat_value((AB+1)'(fx_base) + (AB+1)'(fx_qs));

    // handshakes
    logic in_fire, out_fire, cfg_fire;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;
    assign cfg_fire = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cmr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cfg_ready  = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            cmr_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                cfg_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = cmr_pkg::ST_LOAD;
                end
            end
            cmr_pkg::ST_LOAD:
            begin
                if (held_reg == 2'd0 || (held_reg == 2'd1 && !last_reg))
                begin
                    state_next = cmr_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = cmr_pkg::ST_LEN;
                end
            end
            cmr_pkg::ST_LEN:
            begin
                if (ph_reg && k_reg == 2'd2)
                begin
                    state_next = cmr_pkg::ST_SQRT;
                end
            end
            cmr_pkg::ST_SQRT:
            begin
                if (it_reg == IB'(RB - 1))
                begin
                    state_next = cmr_pkg::ST_STEPS;
                end
            end
            cmr_pkg::ST_STEPS:
            begin
                if (ph_reg)
                begin
                    if (!pass_reg && !final_reg && last_reg)
                    begin
                        state_next = cmr_pkg::ST_LEN;
                    end
                    else
                    begin
                        state_next = cmr_pkg::ST_SEG;
                    end
                end
            end
            cmr_pkg::ST_SEG:
            begin
                state_next = (n_reg == '0) ? cmr_pkg::ST_SEGEND : cmr_pkg::ST_CUBE;
            end
            cmr_pkg::ST_CUBE:
            begin
                if (ph_reg && k_reg == 2'd1)
                begin
                    state_next = cmr_pkg::ST_COEF;
                end
            end
            cmr_pkg::ST_COEF:
            begin
                if (ph_reg && k_reg == 2'd3)
                begin
                    state_next = cmr_pkg::ST_PMUL;
                end
            end
            cmr_pkg::ST_PMUL:
            begin
                if (ph_reg && it_reg[1:0] == 2'd2)
                begin
                    state_next = cmr_pkg::ST_DPREP;
                end
            end
            cmr_pkg::ST_AMUL:
            begin
                if (ph_reg)
                begin
                    state_next = cmr_pkg::ST_DPREP;
                end
            end
            cmr_pkg::ST_DPREP:
            begin
                state_next = cmr_pkg::ST_DIV;
            end
            cmr_pkg::ST_DIV:
            begin
                if (it_reg == IB'(QB - 1))
                begin
                    state_next = cmr_pkg::ST_FIX;
                end
            end
            cmr_pkg::ST_FIX:
            begin
                if (k_reg == 2'd2 && attr_reg)
                begin
                    state_next = cmr_pkg::ST_OUT;
                end
                else if (k_reg == 2'd2 || attr_reg)
                begin
                    state_next = cmr_pkg::ST_AMUL;
                end
                else
                begin
                    state_next = cmr_pkg::ST_PMUL;
                end
            end
            cmr_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (s_reg == n_reg - NB'(1))
                    begin
                        state_next = cmr_pkg::ST_SEGEND;
                    end
                    else
                    begin
                        state_next = cmr_pkg::ST_COEF;
                    end
                end
            end
            cmr_pkg::ST_SEGEND:
            begin
                if (!final_reg && last_reg)
                begin
                    state_next = cmr_pkg::ST_SEG;
                end
                else
                begin
                    state_next = cmr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cmr_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sf_reg    <= cmr_pkg::SF_RESET;
            held_reg  <= 2'd0;
            final_reg <= 1'b0;
            pass_reg  <= 1'b0;
            k_reg     <= 2'd0;
            ph_reg    <= 1'b0;
            it_reg    <= '0;
            attr_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                cmr_pkg::ST_IDLE:
                begin
                    if (cfg_fire)
                    begin
                        sf_reg <= cfg_data;
                    end
                end
                cmr_pkg::ST_LOAD:
                begin
                    k_reg     <= 2'd0;
                    pass_reg  <= 1'b0;
                    final_reg <= (held_reg == 2'd1);
                    case (held_reg)
                        2'd0:    held_reg <= last_reg ? 2'd0 : 2'd1;
                        2'd1:    held_reg <= 2'd2;
                        default: held_reg <= held_reg;
                    endcase
                end
                cmr_pkg::ST_LEN:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        k_reg  <= (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
                        it_reg <= '0;
                    end
                end
                cmr_pkg::ST_SQRT:
                begin
                    it_reg <= it_reg + IB'(1);
                end
                cmr_pkg::ST_STEPS:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg && !pass_reg && !final_reg && last_reg)
                    begin
                        pass_reg <= 1'b1;
                        k_reg    <= 2'd0;
                    end
                end
                cmr_pkg::ST_SEG:
                begin
                    k_reg <= 2'd0;
                end
                cmr_pkg::ST_CUBE, cmr_pkg::ST_COEF:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        k_reg <= (state_reg == cmr_pkg::ST_CUBE && k_reg == 2'd1)
                                 ? 2'd0 : k_reg + 2'd1;
                        it_reg   <= '0;
                        attr_reg <= 1'b0;
                    end
                end
                cmr_pkg::ST_PMUL:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        it_reg <= it_reg + IB'(1);
                    end
                end
                cmr_pkg::ST_AMUL:
                begin
                    ph_reg <= !ph_reg;
                end
                cmr_pkg::ST_DPREP:
                begin
                    it_reg <= '0;
                end
                cmr_pkg::ST_DIV:
                begin
                    it_reg <= it_reg + IB'(1);
                end
                cmr_pkg::ST_FIX:
                begin
                    it_reg <= '0;
                    if (k_reg == 2'd2)
                    begin
                        k_reg    <= 2'd0;
                        attr_reg <= 1'b1;
                    end
                    else
                    begin
                        k_reg <= k_reg + 2'd1;
                    end
                end
                cmr_pkg::ST_OUT:
                begin
                    k_reg <= 2'd0;
                end
                cmr_pkg::ST_SEGEND:
                begin
                    if (!final_reg)
                    begin
                        held_reg  <= last_reg ? 2'd3 : 2'd3;
                        final_reg <= last_reg;
                    end
                    else
                    begin
                        held_reg <= 2'd0;
                    end
                end
                default:
                begin
                    ph_reg <= 1'b0;
                end
            endcase
        end
    end

    // shared product register
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            cmr_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    pd_reg[0] <= pos_x;
                    pd_reg[1] <= pos_y;
                    pd_reg[2] <= pos_z;
                    ad_reg[0] <= scale_value;
                    ad_reg[1] <= twist_value;
                    ad_reg[2] <= falloff_value;
                    last_reg  <= last_point;
                end
            end
            cmr_pkg::ST_LOAD:
            begin
                sum_reg <= '0;
                if (held_reg == 2'd0)
                begin
                    pa_reg <= pd_reg;
                    pb_reg <= pd_reg;
                    ab_reg <= ad_reg;
                end
                else if (held_reg == 2'd1)
                begin
                    pc_reg <= pd_reg;
                    ac_reg <= ad_reg;
                end
            end
            cmr_pkg::ST_LEN:
            begin
                if (ph_reg)
                begin
                    sum_reg <= sum_reg + prod_reg[SB-1:0];
                    if (k_reg == 2'd2)
                    begin
                        sq_x_reg   <= sum_reg + prod_reg[SB-1:0];
                        sq_rem_reg <= '0;
                        root_reg   <= '0;
                    end
                end
            end
            cmr_pkg::ST_SQRT:
            begin
                sq_x_reg   <= {sq_x_reg[SB-3:0], 2'b00};
                sq_rem_reg <= sq_ge ? (RB+2)'(sq_sh - sq_trial) : (RB+2)'(sq_sh);
                root_reg   <= {root_reg[RB-2:0], sq_ge};
            end
            cmr_pkg::ST_STEPS:
            begin
                if (ph_reg)
                begin
                    sum_reg <= '0;
                    if (pass_reg)
                    begin
                        n2_reg <= n_sat;
                    end
                    else
                    begin
                        n_reg <= n_sat;
                    end
                end
            end
            cmr_pkg::ST_SEG:
            begin
                s_reg  <= '0;
                st_reg <= pb_reg;
            end
            cmr_pkg::ST_CUBE:
            begin
                if (ph_reg)
                begin
                    if (k_reg == 2'd0)
                    begin
                        nsq_reg <= prod_reg[2*NB-1:0];
                    end
                    else
                    begin
                        ncb_reg <= prod_reg[CB-1:0];
                    end
                end
            end
            cmr_pkg::ST_COEF:
            begin
                if (ph_reg)
                begin
                    case (k_reg)
                        2'd0:    t2_reg <= prod_reg[2*NB-1:0];
                        2'd1:    t3_reg <= prod_reg[CB-1:0];
                        2'd2:    c1_reg <= prod_reg[CB-1:0];
                        default: c2_reg <= prod_reg[CB-1:0];
                    endcase
                end
            end
            cmr_pkg::ST_PMUL:
            begin
                if (ph_reg)
                begin
                    if (it_reg[1:0] == 2'd0)
                    begin
                        acc_reg <= $signed(prod_reg[AB-1:0]);
                    end
                    else
                    begin
                        acc_reg <= acc_reg + $signed(prod_reg[AB-1:0]);
                    end
                end
            end
            cmr_pkg::ST_AMUL:
            begin
                if (ph_reg)
                begin
                    acc_reg <= $signed(prod_reg[AB-1:0]);
                end
            end
            cmr_pkg::ST_DPREP:
            begin
                dv_neg_reg <= dp_x[AB-1];
                dv_num_reg <= dp_mag[QB-1:0];
                dv_rem_reg <= '0;
                dv_den_reg <= attr_reg ? DVB'({n_reg, 1'b0}) : {ncb_reg, 1'b0};
            end
            cmr_pkg::ST_DIV:
            begin
                dv_rem_reg <= dv_ge ? DVB'(dv_trial - {1'b0, dv_den_reg})
                                    : dv_trial[DVB-1:0];
                dv_num_reg <= {dv_num_reg[QB-2:0], dv_ge};
            end
            cmr_pkg::ST_FIX:
            begin
                if (attr_reg)
                begin
                    oa_reg[k_reg] <= fx_val;
                end
                else
                begin
                    en_reg[k_reg] <= fx_val;
                end
            end
            cmr_pkg::ST_OUT:
            begin
                if (out_fire)
                begin
                    st_reg <= en_reg;
                    s_reg  <= s_reg + NB'(1);
                end
            end
            cmr_pkg::ST_SEGEND:
            begin
                if (!final_reg)
                begin
                    pa_reg <= pb_reg;
                    pb_reg <= pc_reg;
                    pc_reg <= pd_reg;
                    ab_reg <= ac_reg;
                    ac_reg <= ad_reg;
                    n_reg  <= n2_reg;
                end
            end
            default:
            begin
                sum_reg <= sum_reg;
            end
        endcase
    end

    assign start_x     = st_reg[0];
    assign start_y     = st_reg[1];
    assign start_z     = st_reg[2];
    assign end_x       = en_reg[0];
    assign end_y       = en_reg[1];
    assign end_z       = en_reg[2];
    assign out_scale   = oa_reg[0];
    assign out_twist   = oa_reg[1];
    assign out_falloff = oa_reg[2];
    assign last_sample = (s_reg == n_reg - NB'(1))
                         && (final_reg || !last_reg || n2_reg == '0);

endmodule

`default_nettype wire

@@ rtl/cmr_checker.sv @@
// ----------------------------------------------------------------------------
// cmr_checker
// port-level checks of the path sampler, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "catmull_rom_path_sampler_top_macros.svh"

module cmr_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic signed [cmr_pkg::VALUE_BITS-1:0] end_x,
    input wire logic last_sample
);

    // results only while a keypoint is in work
    `CMR_ASSERT_NOW(a_no_out_when_ready, in_ready, !out_valid)

    // an accepted keypoint makes the block busy
    `CMR_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

    // the final result of a keypoint is not followed at once by another
    `CMR_ASSERT_NEXT(a_gap_after_last, out_valid && out_ready && last_sample, !out_valid)

    // a stalled result holds
    `CMR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                     out_valid && $stable(end_x) && $stable(last_sample))

endmodule

bind catmull_rom_path_sampler_top cmr_checker u_cmr_checker (.*);

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// checks the catmull-rom path sampler against a cycle-free model of its math
// ----------------------------------------------------------------------------
// Keypoint paths are sent through the input channel while the output side
// stalls at random. Every accepted keypoint is run through a local model of
// the segment sampler, and the samples it predicts are compared field by
// field with each output beat. The step factor is rewritten between paths.
`default_nettype none

module tb_top;
    import cmr_pkg::*;

    typedef struct {
        value_t sx, sy, sz, ex, ey, ez, sc, tw, fo;
        logic   lst;
    } sample_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [SF_BITS-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    value_t pos_x, pos_y, pos_z, scale_value, twist_value, falloff_value;
    logic last_point;
    logic out_valid;
    logic out_ready;
    value_t start_x, start_y, start_z, end_x, end_y, end_z;
    value_t out_scale, out_twist, out_falloff;
    logic last_sample;

    sample_t expected_samples[$];
    int errors;

    // model state
    longint win_pos[9];
    longint win_attr[9];
    int points_held;
    longint step_factor;

    catmull_rom_path_sampler_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .scale_value(scale_value), .twist_value(twist_value),
        .falloff_value(falloff_value), .last_point(last_point),
        .out_valid(out_valid), .out_ready(out_ready),
        .start_x(start_x), .start_y(start_y), .start_z(start_z),
        .end_x(end_x), .end_y(end_y), .end_z(end_z),
        .out_scale(out_scale), .out_twist(out_twist), .out_falloff(out_falloff),
        .last_sample(last_sample)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint floor_quot(longint num, longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0)
        begin
            q = q - 1;
        end
        return q;
    endfunction

    function automatic value_t clamp_value(longint v);
        if (v > 64'sd8388607)
        begin
            return 24'sh7FFFFF;
        end
        if (v < -64'sd8388608)
        begin
            return 24'sh800000;
        end
        return v[VALUE_BITS-1:0];
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint sub_segment_count(longint d0, longint d1, longint d2);
        longint d[3];
        longint unsigned sum;
        longint unsigned n;
        longint a;
        d[0] = d0;
        d[1] = d1;
        d[2] = d2;
        sum = 0;
        if (step_factor == 0)
        begin
            return 0;
        end
        for (int k = 0; k < 3; k++)
        begin
            a = (d[k] < 0) ? -d[k] : d[k];
            if (a >= (64'sd1 << 25))
            begin
                return MAX_STEPS;
            end
            sum = sum + a * a;
        end
        n = (step_factor * int_sqrt(sum)) >> STEP_SHIFT;
        if (n > MAX_STEPS)
        begin
            n = MAX_STEPS;
        end
        return n;
    endfunction

    // samples of segment b->c; has_next low means the path ends at c
    function automatic void sample_segment(bit has_next, longint nxt[3]);
        longint diff[3], m1[3], v1[3], v2[3];
        longint n, n3, m2, t, num;
        longint v[6];
        longint at[3];
        sample_t smp;
        for (int k = 0; k < 3; k++)
        begin
            diff[k] = win_pos[6+k] - win_pos[3+k];
            m1[k] = win_pos[6+k] - win_pos[k];
            m2 = has_next ? nxt[k] - win_pos[3+k] : diff[k];
            v1[k] = 6 * diff[k] - 2 * m1[k] - m2;
            v2[k] = -4 * diff[k] + m1[k] + m2;
        end
        n = sub_segment_count(diff[0], diff[1], diff[2]);
        n3 = n * n * n;
        for (longint s = 0; s < n; s++)
        begin
            for (int e = 0; e < 2; e++)
            begin
                t = s + e;
                for (int k = 0; k < 3; k++)
                begin
                    num = t * n * n * m1[k] + t * t * n * v1[k] + t * t * t * v2[k];
                    v[e*3+k] = win_pos[3+k] + floor_quot(num + n3, 2 * n3);
                end
            end
            for (int k = 0; k < 3; k++)
            begin
                num = 2 * s * (win_attr[6+k] - win_attr[3+k]) + n;
                at[k] = win_attr[3+k] + floor_quot(num, 2 * n);
            end
            smp.sx = clamp_value(v[0]);
            smp.sy = clamp_value(v[1]);
            smp.sz = clamp_value(v[2]);
            smp.ex = clamp_value(v[3]);
            smp.ey = clamp_value(v[4]);
            smp.ez = clamp_value(v[5]);
            smp.sc = clamp_value(at[0]);
            smp.tw = clamp_value(at[1]);
            smp.fo = clamp_value(at[2]);
            smp.lst = 1'b0;
            expected_samples.push_back(smp);
        end
    endfunction

    function automatic void predict_keypoint(value_t px, value_t py, value_t pz,
                                             value_t sc, value_t tw, value_t fo,
                                             logic lp);
        longint p[3];
        longint a[3];
        int before_cnt;
        before_cnt = expected_samples.size();
        p[0] = px;
        p[1] = py;
        p[2] = pz;
        a[0] = sc;
        a[1] = tw;
        a[2] = fo;
        if (points_held == 0)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_pos[k] = p[k];
                win_pos[3+k] = p[k];
                win_attr[k] = a[k];
                win_attr[3+k] = a[k];
            end
            points_held = 1;
        end
        else if (points_held == 1)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_pos[6+k] = p[k];
                win_attr[6+k] = a[k];
            end
            points_held = 2;
        end
        else
        begin
            sample_segment(1'b1, p);
            for (int k = 0; k < 6; k++)
            begin
                win_pos[k] = win_pos[k+3];
                win_attr[k] = win_attr[k+3];
            end
            for (int k = 0; k < 3; k++)
            begin
                win_pos[6+k] = p[k];
                win_attr[6+k] = a[k];
            end
            points_held = 3;
        end
        if (lp)
        begin
            if (points_held >= 2)
            begin
                sample_segment(1'b0, p);
            end
            points_held = 0;
        end
        if (expected_samples.size() > before_cnt)
        begin
            expected_samples[$].lst = 1'b1;
        end
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch on %s: got %0d, expected %0d", field, got, want);
        errors++;
    endtask

    // output side: random stalls, mostly short
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < 25)
        begin
            stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 3);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        sample_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_samples.size() == 0)
            begin
                $display("unexpected output beat");
                errors++;
            end
            else
            begin
                w = expected_samples.pop_front();
                if (start_x !== w.sx) report_mismatch("start_x", start_x, w.sx);
                if (start_y !== w.sy) report_mismatch("start_y", start_y, w.sy);
                if (start_z !== w.sz) report_mismatch("start_z", start_z, w.sz);
                if (end_x !== w.ex) report_mismatch("end_x", end_x, w.ex);
                if (end_y !== w.ey) report_mismatch("end_y", end_y, w.ey);
                if (end_z !== w.ez) report_mismatch("end_z", end_z, w.ez);
                if (out_scale !== w.sc) report_mismatch("out_scale", out_scale, w.sc);
                if (out_twist !== w.tw) report_mismatch("out_twist", out_twist, w.tw);
                if (out_falloff !== w.fo)
                    report_mismatch("out_falloff", out_falloff, w.fo);
                if (last_sample !== w.lst)
                    report_mismatch("last_sample", last_sample, w.lst);
            end
        end
    end

    task automatic send_keypoint(value_t px, value_t py, value_t pz,
                                 value_t sc, value_t tw, value_t fo, logic lp);
        int gap;
        gap = ($urandom_range(0, 9) < 4) ? 0 :
              (($urandom_range(0, 15) == 0) ? $urandom_range(10, 50)
                                            : $urandom_range(1, 4));
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pos_x <= px;
        pos_y <= py;
        pos_z <= pz;
        scale_value <= sc;
        twist_value <= tw;
        falloff_value <= fo;
        last_point <= lp;
        in_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        predict_keypoint(px, py, pz, sc, tw, fo, lp);
    endtask

    task automatic wait_idle();
        @(posedge clk);
        in_valid <= 1'b0;
        while (expected_samples.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (100) @(posedge clk);
    endtask

    task automatic write_step_factor(logic [SF_BITS-1:0] v);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        step_factor = v;
    endtask

    task automatic test_window_fill();
        // single point, two-point path, zero-length segment
        send_keypoint(24'sd4096, -24'sd4096, 24'sd0, 24'sd1, 24'sd2, 24'sd3, 1'b1);
        send_keypoint(24'sd0, 24'sd0, 24'sd0, 24'sd100, -24'sd100, 24'sd7, 1'b0);
        send_keypoint(24'sd8192, 24'sd4096, -24'sd2048, -24'sd500, 24'sd900, 24'sd0,
                      1'b1);
        send_keypoint(24'sd300, 24'sd300, 24'sd300, 24'sd1, 24'sd1, 24'sd1, 1'b0);
        send_keypoint(24'sd300, 24'sd300, 24'sd300, 24'sd5, 24'sd6, 24'sd7, 1'b0);
        send_keypoint(24'sd2000, 24'sd300, -24'sd1000, 24'sd9, 24'sd8, 24'sd7, 1'b1);
        wait_idle();
    endtask

    task automatic test_field_extremes();
        send_keypoint(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
                      24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 1'b0);
        send_keypoint(24'sh800000, 24'sh800000, 24'sh800000,
                      24'sh800000, 24'sh7FFFFF, 24'sh800000, 1'b0);
        send_keypoint(24'sh000000, 24'shFFFFFF, 24'sh555555,
                      24'shAAAAAA, 24'sh555555, 24'sh000000, 1'b0);
        send_keypoint(24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF,
                      24'sh000001, 24'shFFFFFF, 24'sh123456, 1'b1);
        wait_idle();
    endtask

    task automatic test_step_factor_corners();
        write_step_factor(16'd0);
        send_keypoint(24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0);
        send_keypoint(24'sd40000, 24'sd0, 24'sd0, 24'sd10, 24'sd0, 24'sd0, 1'b0);
        send_keypoint(24'sd80000, 24'sd1000, 24'sd0, 24'sd20, 24'sd0, 24'sd0, 1'b1);
        wait_idle();
        write_step_factor(16'hFFFF);
        send_keypoint(24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0);
        send_keypoint(24'sd100, 24'sd60, -24'sd20, 24'sd4096, 24'sd0, 24'sd0, 1'b0);
        send_keypoint(24'sd150, 24'sd200, 24'sd0, 24'sd0, 24'sd77, -24'sd5, 1'b1);
        wait_idle();
        write_step_factor(16'd1);
        send_keypoint(24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0);
        send_keypoint(24'sh7FFFFF, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b1);
        wait_idle();
    endtask

    task automatic test_random_paths(int total);
        int sent;
        int len;
        longint c[3];
        longint step;
        value_t p[3];
        sent = 0;
        while (sent < total)
        begin
            case ($urandom_range(0, 5))
                0: write_step_factor($urandom_range(0, 65535));
                1, 2: write_step_factor($urandom_range(256, 4096));
                default: ;
            endcase
            step = ($urandom_range(0, 7) == 0) ? 400 : 3000;
            if (step_factor > 8192)
            begin
                step = 200;
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2)
                                              : $urandom_range(3, 8);
            for (int k = 0; k < 3; k++)
            begin
                c[k] = $signed($urandom_range(0, 24'hFFFFFF) << 8) >>> 8;
            end
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 29) == 0)
                begin
                    // noise point anywhere in range
                    for (int k = 0; k < 3; k++)
                    begin
                        p[k] = $urandom();
                    end
                end
                else
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        c[k] = c[k] + $signed($urandom_range(0, 2 * step)) - step;
                        p[k] = clamp_value(c[k]);
                        c[k] = p[k];
                    end
                end
                send_keypoint(p[0], p[1], p[2], $urandom(), $urandom(), $urandom(),
                              i == len - 1);
                sent++;
            end
            wait_idle();
        end
    endtask

    initial
    begin
        errors = 0;
        points_held = 0;
        step_factor = SF_RESET;
        for (int k = 0; k < 9; k++)
        begin
            win_pos[k] = 0;
            win_attr[k] = 0;
        end
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        pos_x = '0;
        pos_y = '0;
        pos_z = '0;
        scale_value = '0;
        twist_value = '0;
        falloff_value = '0;
        last_point = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_window_fill();
        test_field_extremes();
        test_step_factor_corners();
        write_step_factor(SF_RESET);
        test_random_paths(300);
        repeat (200) @(posedge clk);
        if (errors == 0 && expected_samples.size() == 0)
        begin
            $display("[catmull_rom_path_sampler_top] OK");
        end
        else
        begin
            if (expected_samples.size() != 0)
            begin
                $display("%0d expected samples never arrived", expected_samples.size());
            end
            $display("[catmull_rom_path_sampler_top] ERROR");
        end
        $finish;
    end

    initial
    begin
        #400ms;
        $display("[catmull_rom_path_sampler_top] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+rtl
rtl/cmr_pkg.sv
rtl/catmull_rom_path_sampler_top.sv
rtl/cmr_checker.sv
tb/sv/tb_top.sv
